// ----- sv/keyed_duration_table_assert.svh -----
`ifndef KEYED_DURATION_TABLE_ASSERT_SVH
`define KEYED_DURATION_TABLE_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define KDT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kdt check failed");

// next-cycle implication, checked while out of reset
`define KDT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kdt check failed");

`endif

// ----- sv/kdt_pkg.sv -----
package kdt_pkg;
    localparam int DEPTH = 256;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int XW    = 8;
    localparam int CMPW  = (CW > XW) ? CW : XW;
    localparam int KW    = 64;
    localparam int DW    = 32;
    localparam int TW    = 48;

    localparam int SDW = 104;
    localparam int SUW = 3;
    localparam int MDW = 88;
    localparam int MUW = 2;

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_REC = 2'd1;
    localparam logic [1:0] FUNC_QRY = 2'd2;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic          op;
        logic [TW-1:0] a;
        logic [TW-1:0] b;
    } t_alu_req;
endpackage

// ----- sv/kdt_ram.sv -----
module kdt_ram #(
    parameter int AW = 8,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ----- sv/kdt_alu.sv -----
module kdt_alu (
    input  kdt_pkg::t_alu_req          i_req,
    output logic [kdt_pkg::TW-1:0]     o_res
);
    import kdt_pkg::*;

    logic [TW:0] b_ext;
    logic [TW:0] sum;

    // one adder: saturating add, or subtract floored at zero
    always_comb begin
        b_ext = (i_req.op == ALU_SUB) ? ~{1'b0, i_req.b} : {1'b0, i_req.b};
        sum   = {1'b0, i_req.a} + b_ext + {{TW{1'b0}}, (i_req.op == ALU_SUB)};
        if (i_req.op == ALU_SUB) begin
            o_res = sum[TW] ? '0 : sum[TW-1:0];
        end else begin
            o_res = sum[TW] ? '1 : sum[TW-1:0];
        end
    end
endmodule

// ----- sv/keyed_duration_table.sv -----
// Add scans the key RAM one entry per cycle, appends the key on a miss and reads the
// duration of entry j on a hit at index j. Record writes the entry and query reads it,
// skipping the read for an unoccupied entry, an invalid index or the unused code. One
// item at a time: the next is taken once the result sits in the output register, which
// holds it. Reset (synchronous, active low) empties the table and clears both totals;
// the RAMs are not swept, entries beyond the fill count are never read.
module keyed_duration_table (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    // [63:0] target_key, [71:64] entry_index, [103:72] time_ms
    input  logic [kdt_pkg::SDW-1:0] i_s_tdata,
    // [1:0] func, [2] index_valid
    input  logic [kdt_pkg::SUW-1:0] i_s_tuser,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    // [7:0] result_index, [39:8] entry_time_ms, [87:40] remaining_ms
    output logic [kdt_pkg::MDW-1:0] o_m_tdata,
    // [0] hit, [1] table_full
    output logic [kdt_pkg::MUW-1:0] o_m_tuser
);
    import kdt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MISS = 3'd2;
    localparam logic [2:0] S_REC  = 3'd3;
    localparam logic [2:0] S_DRD  = 3'd4;
    localparam logic [2:0] S_DDAT = 3'd5;
    localparam logic [2:0] S_REM  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]     r_state, n_state;
    logic [1:0]     r_func, n_func;
    logic [KW-1:0]  r_key, n_key;
    logic [XW-1:0]  r_idx, n_idx;
    logic           r_ivld, n_ivld;
    logic [DW-1:0]  r_tms, n_tms;
    logic [IW-1:0]  r_j, n_j;
    logic [CW-1:0]  r_count, n_count;
    logic [TW-1:0]  r_exp, n_exp;
    logic [TW-1:0]  r_spent, n_spent;
    logic [XW-1:0]  r_res_idx, n_res_idx;
    logic           r_hit, n_hit;
    logic           r_full, n_full;
    logic [DW-1:0]  r_time, n_time;
    logic [TW-1:0]  r_rem, n_rem;
    logic           r_ovalid, n_ovalid;
    logic [MDW-1:0] r_odata, n_odata;
    logic [MUW-1:0] r_ouser, n_ouser;

    logic           occ;
    logic           in_occ;
    logic           room;
    logic           key_we;
    logic [IW-1:0]  key_raddr;
    logic [KW-1:0]  key_rdata;
    logic           dur_we;
    logic [IW-1:0]  dur_waddr;
    logic [DW-1:0]  dur_wdata;
    logic [IW-1:0]  dur_raddr;
    logic [DW-1:0]  dur_rdata;
    t_alu_req       alu_req;
    logic [TW-1:0]  alu_res;

    assign occ    = r_ivld && (CMPW'(r_idx) < CMPW'(r_count));
    assign in_occ = i_s_tuser[2] && (CMPW'(i_s_tdata[71:64]) < CMPW'(r_count));
    assign room   = r_count < CW'(DEPTH);

    assign key_we    = (r_state == S_MISS) && room;
    assign key_raddr = (r_state == S_SCAN) ? r_j + IW'(1) : '0;

    assign dur_we    = key_we || ((r_state == S_REC) && occ);
    assign dur_waddr = (r_state == S_MISS) ? r_count[IW-1:0] : IW'(r_idx);
    assign dur_wdata = (r_state == S_MISS) ? '0 : r_tms;
    assign dur_raddr = (r_func == FUNC_ADD) ? r_j : IW'(r_idx);

    kdt_ram #(.AW(IW), .DW(KW)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (r_key),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    kdt_ram #(.AW(IW), .DW(DW)) u_dur_ram (
        .i_clk   (i_clk),
        .i_we    (dur_we),
        .i_waddr (dur_waddr),
        .i_wdata (dur_wdata),
        .i_raddr (dur_raddr),
        .o_rdata (dur_rdata)
    );

    kdt_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_key     = r_key;
        n_idx     = r_idx;
        n_ivld    = r_ivld;
        n_tms     = r_tms;
        n_j       = r_j;
        n_count   = r_count;
        n_exp     = r_exp;
        n_spent   = r_spent;
        n_res_idx = r_res_idx;
        n_hit     = r_hit;
        n_full    = r_full;
        n_time    = r_time;
        n_rem     = r_rem;
        n_ovalid  = r_ovalid && !i_m_tready;
        n_odata   = r_odata;
        n_ouser   = r_ouser;
        alu_req   = '{op: ALU_ADD, a: r_exp, b: TW'(dur_rdata)};

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_func    = i_s_tuser[1:0];
                    n_ivld    = i_s_tuser[2];
                    n_key     = i_s_tdata[63:0];
                    n_idx     = i_s_tdata[71:64];
                    n_tms     = i_s_tdata[103:72];
                    n_res_idx = i_s_tdata[71:64];
                    n_hit     = 1'b0;
                    n_full    = 1'b0;
                    n_time    = '0;
                    n_j       = '0;
                    case (i_s_tuser[1:0])
                        FUNC_ADD: n_state = (r_count == '0) ? S_MISS : S_SCAN;
                        FUNC_REC: n_state = S_REC;
                        FUNC_QRY: n_state = in_occ ? S_DRD : S_REM;
                        default:  n_state = S_REM;
                    endcase
                end
            end
            S_SCAN: begin
                // key RAM data belongs to entry r_j
                if (key_rdata == r_key) begin
                    n_res_idx = XW'(r_j);
                    n_hit     = 1'b1;
                    n_state   = S_DRD;
                end else if (CW'(r_j) + CW'(1) == r_count) begin
                    n_state = S_MISS;
                end else begin
                    n_j = r_j + IW'(1);
                end
            end
            S_MISS: begin
                if (room) begin
                    n_res_idx = XW'(r_count);
                    n_count   = r_count + CW'(1);
                end else begin
                    n_full = 1'b1;
                end
                n_state = S_REM;
            end
            S_REC: begin
                alu_req = '{op: ALU_ADD, a: r_spent, b: TW'(r_tms)};
                if (occ) begin
                    n_spent = alu_res;
                    n_time  = r_tms;
                end
                n_state = S_REM;
            end
            S_DRD: begin
                n_state = S_DDAT;
            end
            S_DDAT: begin
                n_time = dur_rdata;
                if (r_func == FUNC_ADD) begin
                    n_exp = alu_res;
                end
                n_state = S_REM;
            end
            S_REM: begin
                alu_req = '{op: ALU_SUB, a: r_exp, b: r_spent};
                n_rem   = alu_res;
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_ovalid || i_m_tready) begin
                    n_odata  = {r_rem, r_time, r_res_idx};
                    n_ouser  = {r_full, r_hit};
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_exp    <= '0;
            r_spent  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_exp    <= n_exp;
            r_spent  <= n_spent;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_key     <= n_key;
        r_idx     <= n_idx;
        r_ivld    <= n_ivld;
        r_tms     <= n_tms;
        r_j       <= n_j;
        r_res_idx <= n_res_idx;
        r_hit     <= n_hit;
        r_full    <= n_full;
        r_time    <= n_time;
        r_rem     <= n_rem;
        r_odata   <= n_odata;
        r_ouser   <= n_ouser;
    end
endmodule

// ----- sv/kdt_checker.sv -----
`include "keyed_duration_table_assert.svh"

module kdt_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_s_tvalid,
    input logic                    o_s_tready,
    input logic                    o_m_tvalid,
    input logic                    i_m_tready,
    input logic [kdt_pkg::MDW-1:0] o_m_tdata,
    input logic [kdt_pkg::MUW-1:0] o_m_tuser
);
    // a result waiting downstream stays offered
    `KDT_ASSERT_NXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid)
    // the block is busy in the cycle after it accepts an item
    `KDT_ASSERT_NXT(a_busy_after_accept, i_s_tvalid && o_s_tready, !o_s_tready)
    // a lookup cannot both hit and find the table full
    `KDT_ASSERT_IMP(a_hit_full_excl, o_m_tvalid, !(o_m_tuser[0] && o_m_tuser[1]))
    // a full-table result carries a zero entry time
    `KDT_ASSERT_IMP(a_full_no_time, o_m_tvalid && o_m_tuser[1], o_m_tdata[39:8] == 32'd0)
endmodule

bind keyed_duration_table kdt_checker u_kdt_checker (.*);

// ----- dv/keyed_duration_table_tb.sv -----
typedef struct {
    logic [1:0]  func;
    logic [63:0] key;
    logic [7:0]  idx;
    logic        idx_ok;
    logic [31:0] dur;
} t_job_req;

typedef struct {
    logic [7:0]  index;
    logic        hit;
    logic        full;
    logic [31:0] dur;
    logic [47:0] remaining;
} t_job_res;

// Mirror of the key table and both totals; holds the results still owed by the block.
class ledger_model;
    logic [63:0] keys[kdt_pkg::DEPTH];
    logic [31:0] durs[kdt_pkg::DEPTH];
    int          fill;
    logic [47:0] planned_ms;
    logic [47:0] spent_ms;
    t_job_res    due_results[$];
    int          bad_count;

    function new();
        fill       = 0;
        planned_ms = '0;
        spent_ms   = '0;
        bad_count  = 0;
        foreach (durs[i]) durs[i] = '0;
    endfunction

    function logic [47:0] sat_add(logic [47:0] base, logic [31:0] amount);
        logic [48:0] sum;
        sum = {1'b0, base} + {17'd0, amount};
        return sum[48] ? {48{1'b1}} : sum[47:0];
    endfunction

    function void take_request(t_job_req r);
        t_job_res res;
        int       at;
        bit       live;
        res.index = r.idx;
        res.hit   = 1'b0;
        res.full  = 1'b0;
        res.dur   = '0;
        at        = -1;
        live      = r.idx_ok && (int'(r.idx) < fill);
        case (r.func)
            kdt_pkg::FUNC_ADD: begin
                for (int j = 0; j < fill; j++) begin
                    if (keys[j] == r.key) begin
                        at = j;
                        break;
                    end
                end
                if (at >= 0) begin
                    planned_ms = sat_add(planned_ms, durs[at]);
                    res.index  = at[7:0];
                    res.hit    = 1'b1;
                    res.dur    = durs[at];
                end else if (fill < kdt_pkg::DEPTH) begin
                    keys[fill] = r.key;
                    durs[fill] = '0;
                    res.index  = fill[7:0];
                    fill++;
                end else begin
                    res.full = 1'b1;
                end
            end
            kdt_pkg::FUNC_REC: begin
                if (live) begin
                    spent_ms     = sat_add(spent_ms, r.dur);
                    durs[r.idx]  = r.dur;
                    res.dur      = r.dur;
                end
            end
            kdt_pkg::FUNC_QRY: begin
                if (live) res.dur = durs[r.idx];
            end
            default: ;
        endcase
        res.remaining = (spent_ms >= planned_ms) ? '0 : planned_ms - spent_ms;
        due_results.push_back(res);
    endfunction

    task log_mismatch(string what);
        bad_count++;
        $display("mismatch: %s", what);
    endtask

    task match_result(t_job_res got);
        t_job_res want;
        if (due_results.size() == 0) begin
            log_mismatch("result item with nothing outstanding");
            return;
        end
        want = due_results.pop_front();
        if (got.index !== want.index)
            log_mismatch($sformatf("result_index got %0h want %0h", got.index, want.index));
        if (got.hit !== want.hit)
            log_mismatch($sformatf("hit got %0b want %0b", got.hit, want.hit));
        if (got.full !== want.full)
            log_mismatch($sformatf("table_full got %0b want %0b", got.full, want.full));
        if (got.dur !== want.dur)
            log_mismatch($sformatf("entry_time_ms got %0h want %0h", got.dur, want.dur));
        if (got.remaining !== want.remaining)
            log_mismatch($sformatf("remaining_ms got %0h want %0h",
                                   got.remaining, want.remaining));
    endtask
endclass

module keyed_duration_table_tb;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    // [63:0] target_key, [71:64] entry_index, [103:72] time_ms
    logic [kdt_pkg::SDW-1:0] i_s_tdata;
    // [1:0] func, [2] index_valid
    logic [kdt_pkg::SUW-1:0] i_s_tuser;
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    // [7:0] result_index, [39:8] entry_time_ms, [87:40] remaining_ms
    logic [kdt_pkg::MDW-1:0] o_m_tdata;
    // [0] hit, [1] table_full
    logic [kdt_pkg::MUW-1:0] o_m_tuser;

    ledger_model book;
    bit          calm;
    int unsigned hold_left;

    keyed_duration_table DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #80_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_job_req make_job(logic [1:0] func, logic [63:0] key,
                                          logic [7:0] idx, logic idx_ok, logic [31:0] dur);
        t_job_req r;
        r.func   = func;
        r.key    = key;
        r.idx    = idx;
        r.idx_ok = idx_ok;
        r.dur    = dur;
        return r;
    endfunction

    // Filling favors new keys so the table fills; later mostly hits, records and queries.
    function automatic t_job_req random_job(bit filling);
        t_job_req    r;
        int unsigned pick;
        int unsigned new_pct;
        pick     = $urandom_range(0, 99);
        new_pct  = filling ? 90 : 30;
        r.key    = {$urandom, $urandom};
        r.idx    = 8'($urandom_range(0, 255));
        r.idx_ok = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 3))
            0:       r.dur = $urandom_range(0, 1) ? '1 : '0;
            default: r.dur = $urandom;
        endcase
        if (pick < (filling ? 75 : 40)) begin
            r.func = kdt_pkg::FUNC_ADD;
            if (book.fill != 0 && $urandom_range(0, 99) >= new_pct)
                r.key = book.keys[$urandom_range(0, book.fill - 1)];
        end else if (pick < (filling ? 87 : 70)) begin
            r.func = kdt_pkg::FUNC_REC;
        end else if (pick < (filling ? 95 : 92)) begin
            r.func = kdt_pkg::FUNC_QRY;
        end else begin
            r.func = FUNC_NONE;
        end
        if (r.func != kdt_pkg::FUNC_ADD && book.fill != 0 && $urandom_range(0, 9) < 8)
            r.idx = 8'($urandom_range(0, book.fill - 1));
        return r;
    endfunction

    // Keep tvalid high across back-to-back items; drop it only for a gap.
    task automatic send_job(t_job_req r);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {r.dur, r.idx, r.key};
        i_s_tuser  <= {r.idx_ok, r.func};
        do @(posedge i_clk); while (!o_s_tready);
        book.take_request(r);
    endtask

    initial begin
        t_job_res got;
        i_m_tready = 1'b0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got.index     = o_m_tdata[7:0];
                got.dur       = o_m_tdata[39:8];
                got.remaining = o_m_tdata[87:40];
                got.hit       = o_m_tuser[0];
                got.full      = o_m_tuser[1];
                book.match_result(got);
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                hold_left = pick_gap();
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        book       = new();
        calm       = 1'b0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, unoccupied and invalid indexes, hits, unused func code
        send_job(make_job(kdt_pkg::FUNC_QRY, '0, 8'd0, 1'b1, '0));
        send_job(make_job(kdt_pkg::FUNC_REC, '0, 8'd255, 1'b1, '1));
        send_job(make_job(kdt_pkg::FUNC_ADD, '0, 8'd255, 1'b0, '0));
        send_job(make_job(kdt_pkg::FUNC_ADD, '1, 8'd0, 1'b1, '1));
        send_job(make_job(kdt_pkg::FUNC_ADD, '0, 8'd0, 1'b0, '0));
        send_job(make_job(kdt_pkg::FUNC_REC, '0, 8'd0, 1'b1, '1));
        send_job(make_job(kdt_pkg::FUNC_ADD, '0, 8'd0, 1'b1, '0));
        send_job(make_job(kdt_pkg::FUNC_REC, '1, 8'd1, 1'b1, '0));
        send_job(make_job(kdt_pkg::FUNC_ADD, '1, 8'd255, 1'b1, '1));
        send_job(make_job(kdt_pkg::FUNC_QRY, '0, 8'd1, 1'b0, '0));
        send_job(make_job(kdt_pkg::FUNC_REC, '0, 8'd0, 1'b0, 32'd5));
        send_job(make_job(kdt_pkg::FUNC_QRY, '1, 8'd0, 1'b1, '1));
        send_job(make_job(FUNC_NONE, 64'h5a5a_0f0f_a5a5_f0f0, 8'haa, 1'b1, 32'hdead_beef));
        send_job(make_job(FUNC_NONE, '1, 8'hff, 1'b0, '1));
        send_job(make_job(kdt_pkg::FUNC_REC, '0, 8'd2, 1'b1, 32'h0000_0042));
        send_job(make_job(kdt_pkg::FUNC_REC, '0, 8'd1, 1'b1, 32'h1234_5678));
        send_job(make_job(kdt_pkg::FUNC_ADD, '0, 8'd0, 1'b1, '0));
        send_job(make_job(kdt_pkg::FUNC_ADD, 64'h8000_0000_0000_0001, 8'd7, 1'b1, '0));
        send_job(make_job(kdt_pkg::FUNC_QRY, '0, 8'd255, 1'b1, '0));
        send_job(make_job(kdt_pkg::FUNC_ADD, '1, 8'd0, 1'b1, '0));

        for (int n = 0; n < 700; n++) begin
            if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
            send_job(random_job(n < 400));
        end
        i_s_tvalid <= 1'b0;

        while (book.due_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (book.due_results.size() != 0)
            book.log_mismatch("expected result items never arrived");
        if (book.bad_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+sv
sv/kdt_pkg.sv
sv/kdt_ram.sv
sv/kdt_alu.sv
sv/keyed_duration_table.sv
sv/kdt_checker.sv
dv/keyed_duration_table_tb.sv
